// ===== sv/csp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg
// Shared constants and types of the convex sector point locator.
// ----------------------------------------------------------------------------
package csp_pkg;

	// Number of sector slots; identifier 0 is never used.
	localparam int SECTOR_SLOTS = 128;
	// Width of a sector identifier.
	localparam int ID_W = $clog2(SECTOR_SLOTS);
	// Width of the next-identifier counter, which can reach SECTOR_SLOTS.
	localparam int NEXT_W = $clog2(SECTOR_SLOTS + 1);
	// Address width of the corner store, four corners per sector.
	localparam int ADDR_W = ID_W + 2;

	// Action codes.
	localparam logic [1:0] ACT_CORNER = 2'd0;
	localparam logic [1:0] ACT_COMMIT = 2'd1;
	localparam logic [1:0] ACT_LOCATE = 2'd2;

	// Plane numbers: walls 0 to 3, then ceiling and floor.
	localparam logic [2:0] PLANE_CEIL  = 3'd4;
	localparam logic [2:0] PLANE_FLOOR = 3'd5;

	// One point in raw Q8.8 coordinates.
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} vec_t;

	// Status from the plane unit to the sequencer.
	typedef struct packed {
		logic done;
		logic pass;
	} pe_status_t;

endpackage
`default_nettype wire

// ===== sv/csp_sector_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csp_sector_mem
// Corner store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csp_sector_mem (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [csp_pkg::ADDR_W-1:0] waddr,
	input  wire logic [63:0]                wdata,
	input  wire logic [csp_pkg::ADDR_W-1:0] raddr,
	output logic      [63:0]                rdata
);

	logic [63:0] mem [csp_pkg::SECTOR_SLOTS*4];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/csp_plane_eval.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csp_plane_eval
// Sign test of cross(b-a, c-a) . (a-q) with one shared multiplier over ten steps.
// ----------------------------------------------------------------------------
module csp_plane_eval (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire csp_pkg::vec_t       a,
	input  wire csp_pkg::vec_t       b,
	input  wire csp_pkg::vec_t       c,
	input  wire csp_pkg::vec_t       q,
	output csp_pkg::pe_status_t      status
);

	logic               run_q;
	logic [3:0]         st_q;
	logic signed [16:0] bx_q, by_q, bz_q, cx_q, cy_q, cz_q, dx_q, dy_q, dz_q;
	logic signed [34:0] nx_q, ny_q, nz_q;
	logic signed [51:0] prod_q;
	logic signed [53:0] acc_q;
	logic signed [34:0] ma;
	logic signed [16:0] mb;
	logic signed [51:0] mul_w;
	logic signed [53:0] final_w;
	logic signed [34:0] prod_lo;

	// Operand selection for the shared multiplier.
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			4'd0: begin ma = 35'(by_q); mb = cz_q; end
			4'd1: begin ma = 35'(bz_q); mb = cy_q; end
			4'd2: begin ma = 35'(bz_q); mb = cx_q; end
			4'd3: begin ma = 35'(bx_q); mb = cz_q; end
			4'd4: begin ma = 35'(bx_q); mb = cy_q; end
			4'd5: begin ma = 35'(by_q); mb = cx_q; end
			4'd6: begin ma = nx_q; mb = dx_q; end
			4'd7: begin ma = ny_q; mb = dy_q; end
			4'd8: begin ma = nz_q; mb = dz_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign mul_w   = ma * mb;
	assign prod_lo = $signed(prod_q[34:0]);
	assign final_w = acc_q + 54'(prod_q);

	// Datapath registers; each step consumes the product of the step before.
	always_ff @(posedge clk) begin
		if (start) begin
			bx_q <= 17'(b.x) - 17'(a.x);
			by_q <= 17'(b.y) - 17'(a.y);
			bz_q <= 17'(b.z) - 17'(a.z);
			cx_q <= 17'(c.x) - 17'(a.x);
			cy_q <= 17'(c.y) - 17'(a.y);
			cz_q <= 17'(c.z) - 17'(a.z);
			dx_q <= 17'(a.x) - 17'(q.x);
			dy_q <= 17'(a.y) - 17'(q.y);
			dz_q <= 17'(a.z) - 17'(q.z);
		end
		prod_q <= mul_w;
		if (run_q) begin
			case (st_q)
				4'd1: nx_q <= prod_lo;
				4'd2: nx_q <= nx_q - prod_lo;
				4'd3: ny_q <= prod_lo;
				4'd4: ny_q <= ny_q - prod_lo;
				4'd5: nz_q <= prod_lo;
				4'd6: nz_q <= nz_q - prod_lo;
				4'd7: acc_q <= 54'(prod_q);
				4'd8: acc_q <= final_w;
				default: ;
			endcase
		end
	end

	// Step counter and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			st_q        <= '0;
			status.done <= 1'b0;
			status.pass <= 1'b0;
		end else begin
			status.done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				st_q  <= '0;
			end else if (run_q) begin
				if (st_q == 4'd9) begin
					run_q       <= 1'b0;
					status.done <= 1'b1;
					status.pass <= !final_w[53];
				end else begin
					st_q <= st_q + 4'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/convex_sector_point_locator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// convex_sector_point_locator
// Stores convex six-plane sectors and finds the first one that holds a point.
// ----------------------------------------------------------------------------
// A corner write and a refused commit raise done in the cycle after start; a
// commit copies the four staged corners, one after another, through the store's
// write port. A locate visits sectors from 1 upward: it reads four corners from
// the store, then tests the six planes in turn on the shared multiplier.
// One item at a time; the result strobe done lasts one cycle and cannot stall.
// Reset clears control state and sets the next identifier to 1.
// ----------------------------------------------------------------------------
module convex_sector_point_locator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         action,
	input  wire logic [1:0]         corner,
	input  wire logic signed [15:0] corner_x,
	input  wire logic signed [15:0] corner_z,
	input  wire logic signed [15:0] corner_y_bottom,
	input  wire logic signed [15:0] corner_y_top,
	input  wire logic signed [15:0] point_x,
	input  wire logic signed [15:0] point_y,
	input  wire logic signed [15:0] point_z,
	output logic                    done,
	output logic [6:0]              sector_number,
	output logic                    table_full
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_COMMIT,
		S_CHECK,
		S_LOAD,
		S_PLANE,
		S_WAIT
	} state_t;

	state_t                        state_q;
	logic [63:0]                   stg_q [4];
	logic [63:0]                   cor_q [4];
	logic [csp_pkg::NEXT_W-1:0]    next_q;
	logic [csp_pkg::NEXT_W-1:0]    id_q;
	logic [2:0]                    cnt_q;
	logic [2:0]                    pl_q;
	csp_pkg::vec_t                 pt_q;
	logic                          pe_start;
	csp_pkg::pe_status_t           pe_st;
	csp_pkg::vec_t                 pa, pb, pc;
	logic [63:0]                   rdata;
	logic                          mem_we;
	logic [csp_pkg::ADDR_W-1:0]    waddr, raddr;
	logic [1:0]                    wn;

	assign busy     = (state_q != S_IDLE);
	assign mem_we   = (state_q == S_COMMIT);
	assign waddr    = {next_q[csp_pkg::ID_W-1:0], cnt_q[1:0]};
	assign raddr    = {id_q[csp_pkg::ID_W-1:0], cnt_q[1:0]};
	assign pe_start = (state_q == S_PLANE);
	assign wn       = pl_q[1:0] + 2'd1;

	// Corner unpacking for the current plane.
	function automatic csp_pkg::vec_t corner_pt(input logic [63:0] c, input logic top);
		csp_pkg::vec_t v;
		v.x = c[15:0];
		v.z = c[31:16];
		v.y = top ? c[63:48] : c[47:32];
		return v;
	endfunction

	// Plane corner selection: walls, ceiling, floor.
	always_comb begin
		if (pl_q == csp_pkg::PLANE_CEIL) begin
			pa = corner_pt(cor_q[0], 1'b1);
			pb = corner_pt(cor_q[1], 1'b1);
			pc = corner_pt(cor_q[2], 1'b1);
		end else if (pl_q == csp_pkg::PLANE_FLOOR) begin
			pa = corner_pt(cor_q[0], 1'b0);
			pb = corner_pt(cor_q[2], 1'b0);
			pc = corner_pt(cor_q[1], 1'b0);
		end else begin
			pa = corner_pt(cor_q[pl_q[1:0]], 1'b0);
			pb = corner_pt(cor_q[pl_q[1:0]], 1'b1);
			pc = corner_pt(cor_q[wn], 1'b0);
		end
	end

	csp_sector_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (stg_q[cnt_q[1:0]]),
		.raddr (raddr),
		.rdata (rdata)
	);

	csp_plane_eval u_plane (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pe_start),
		.a      (pa),
		.b      (pb),
		.c      (pc),
		.q      (pt_q),
		.status (pe_st)
	);

	// Staging corners, loaded corners and query point.
	always_ff @(posedge clk) begin
		if (start && !busy && action == csp_pkg::ACT_CORNER) begin
			stg_q[corner] <= {corner_y_top, corner_y_bottom, corner_z, corner_x};
		end
		if (start && !busy && action == csp_pkg::ACT_LOCATE) begin
			pt_q.x <= point_x;
			pt_q.y <= point_y;
			pt_q.z <= point_z;
		end
		if (state_q == S_LOAD && cnt_q != 3'd0) begin
			cor_q[2'(cnt_q - 3'd1)] <= rdata;
		end
	end

	// Sequencer and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			next_q        <= csp_pkg::NEXT_W'(1);
			id_q          <= '0;
			cnt_q         <= '0;
			pl_q          <= '0;
			done          <= 1'b0;
			sector_number <= '0;
			table_full    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						sector_number <= '0;
						table_full    <= 1'b0;
						cnt_q         <= '0;
						case (action)
							csp_pkg::ACT_COMMIT: begin
								if (next_q >= csp_pkg::NEXT_W'(csp_pkg::SECTOR_SLOTS)) begin
									table_full <= 1'b1;
									done       <= 1'b1;
								end else begin
									state_q <= S_COMMIT;
								end
							end
							csp_pkg::ACT_LOCATE: begin
								id_q    <= csp_pkg::NEXT_W'(1);
								state_q <= S_CHECK;
							end
							default: done <= 1'b1;
						endcase
					end
				end
				S_COMMIT: begin
					if (cnt_q == 3'd3) begin
						sector_number <= 7'(next_q);
						next_q        <= next_q + csp_pkg::NEXT_W'(1);
						done          <= 1'b1;
						state_q       <= S_IDLE;
					end
					cnt_q <= cnt_q + 3'd1;
				end
				S_CHECK: begin
					cnt_q <= '0;
					pl_q  <= '0;
					if (id_q >= next_q) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (cnt_q == 3'd4) begin
						state_q <= S_PLANE;
					end
					cnt_q <= cnt_q + 3'd1;
				end
				S_PLANE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (pe_st.done) begin
						if (!pe_st.pass) begin
							id_q    <= id_q + csp_pkg::NEXT_W'(1);
							state_q <= S_CHECK;
						end else if (pl_q == csp_pkg::PLANE_FLOOR) begin
							sector_number <= 7'(id_q);
							done          <= 1'b1;
							state_q       <= S_IDLE;
						end else begin
							pl_q    <= pl_q + 3'd1;
							state_q <= S_PLANE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
